// File: hw/rtl/slss_pkg.sv
// ============================================================================
// slss_pkg
// Types, register indexes, reset values and pulse conversion for the leg
// sweep sequencer.
// ============================================================================
package slss_pkg;

	typedef enum logic [2:0] {
		REG_HIP_LOW       = 3'd0,
		REG_HIP_HIGH      = 3'd1,
		REG_THIGH_LIFTED  = 3'd2,
		REG_THIGH_LOWERED = 3'd3,
		REG_SHIN_LIFTED   = 3'd4,
		REG_SHIN_LOWERED  = 3'd5,
		REG_TICK_INTERVAL = 3'd6,
		REG_SWEEP_MODE    = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		JOINT_HIP   = 2'd0,
		JOINT_FEMUR = 2'd1,
		JOINT_TIBIA = 2'd2
	} joint_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ELAPSED_W  = 17;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	localparam logic [7:0]  RST_HIP_LOW       = 8'd35;
	localparam logic [7:0]  RST_HIP_HIGH      = 8'd110;
	localparam logic [7:0]  RST_THIGH_LIFTED  = 8'd80;
	localparam logic [7:0]  RST_THIGH_LOWERED = 8'd150;
	localparam logic [7:0]  RST_SHIN_LIFTED   = 8'd50;
	localparam logic [7:0]  RST_SHIN_LOWERED  = 8'd100;
	localparam logic [15:0] RST_TICK_INTERVAL = 16'd10;
	localparam logic [1:0]  RST_SWEEP_MODE    = 2'd3;

	// pulse = 120 + a*460/180 = 120 + floor(a*23/9); /9 by reciprocal 7282/2^16,
	// exact for a*23 below 8192
	localparam logic [9:0]  PULSE_BASE  = 10'd120;
	localparam logic [9:0]  PULSE_MAX   = 10'd1023;
	localparam logic [12:0] RECIP_MUL   = 13'd7282;
	localparam int          RECIP_SHIFT = 16;

	// one queued step: a hip move (single result) or a bound pair
	typedef struct packed {
		logic       pair;
		logic [7:0] angle0;
		logic [7:0] angle1;
		logic       down;
	} step_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [9:0] pulse_of(input logic [7:0] a);
		logic [12:0] x;
		logic [25:0] prod;
		logic [10:0] sum;
		x    = ({5'd0, a} << 4) + ({5'd0, a} << 2) + ({5'd0, a} << 1) + {5'd0, a};
		prod = {13'd0, x} * {13'd0, RECIP_MUL};
		sum  = {1'b0, PULSE_BASE} + {1'b0, prod[RECIP_SHIFT +: 10]};
		return (sum > {1'b0, PULSE_MAX}) ? PULSE_MAX : sum[9:0];
	endfunction

endpackage

// File: hw/rtl/servo_leg_sweep_sequencer.sv
// ============================================================================
// servo_leg_sweep_sequencer
// Hip sweep sequencer for one leg: counts ticks, steps the hip and reports
// femur/tibia angles at each bound.
// ============================================================================
// A stepping tick is written into the step queue, then popped into the output register.
// Throughput: one tick per cycle unless the input stalls; a bound step gives a femur then a tibia result.
// Input stalls only while the QUEUE_DEPTH-entry step queue is full.
// Reset: registers take their defaults, elapsed count saturated so the first
// tick steps, leg marked down, no results pending.
module servo_leg_sweep_sequencer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [slss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            tick,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      joint,
	output logic [7:0]                      angle,
	output logic [9:0]                      pulse,
	output logic                            leg_down,
	output logic                            last
);
	import slss_pkg::*;

	logic    accept;
	logic    push;
	logic    pop;
	step_t   push_step;
	step_t   head;
	q_stat_t q_stat;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;

	slss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.tick      (tick),
		.push      (push),
		.push_step (push_step)
	);

	slss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_step (push_step),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	slss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.joint     (joint),
		.angle     (angle),
		.pulse     (pulse),
		.leg_down  (leg_down),
		.last      (last)
	);

endmodule

// File: hw/rtl/slss_front.sv
// ============================================================================
// slss_front
// Configuration registers, tick counting and sweep state; turns each tick
// that steps into one queued step.
// ============================================================================
module slss_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [slss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [slss_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               accept,
	input  logic                               tick,
	output logic                               push,
	output slss_pkg::step_t                    push_step
);
	import slss_pkg::*;

	logic [7:0]           hip_low_q, hip_high_q, thigh_lifted_q, thigh_lowered_q;
	logic [7:0]           shin_lifted_q, shin_lowered_q;
	logic [15:0]          tick_interval_q;
	logic [1:0]           sweep_mode_q;
	logic [7:0]           hip_q;
	logic                 moving_up_q;
	logic                 down_q;
	logic [ELAPSED_W-1:0] elapsed_q;

	logic [ELAPSED_W-1:0] elapsed_inc;
	logic                 step_go;
	logic                 at_upper, at_lower;
	logic [7:0]           low_nx, high_nx;
	logic [1:0]           mode_nx;
	cfg_reg_t             reg_sel;

	assign reg_sel = cfg_reg_t'(cfg_index);

	always_comb begin
		low_nx  = (cfg_wr_en && reg_sel == REG_HIP_LOW) ? cfg_data[7:0] : hip_low_q;
		high_nx = (cfg_wr_en && reg_sel == REG_HIP_HIGH) ? cfg_data[7:0] : hip_high_q;
		mode_nx = (cfg_wr_en && reg_sel == REG_SWEEP_MODE) ? cfg_data[1:0] : sweep_mode_q;
	end

	always_comb begin
		elapsed_inc = (elapsed_q == ELAPSED_MAX) ? ELAPSED_MAX : elapsed_q + 1'b1;
		step_go     = accept && tick && (elapsed_inc > {1'b0, tick_interval_q});
		at_upper    = moving_up_q && !(hip_q < hip_high_q);
		at_lower    = !moving_up_q && !(hip_q > hip_low_q);
		push_step.pair   = at_upper || at_lower;
		push_step.angle1 = at_upper ? shin_lifted_q : shin_lowered_q;
		priority if (at_upper) begin
			push_step.angle0 = thigh_lifted_q;
			push_step.down   = 1'b1;
		end else if (at_lower) begin
			push_step.angle0 = thigh_lowered_q;
			push_step.down   = 1'b0;
		end else begin
			push_step.angle0 = moving_up_q ? hip_q + 8'd1 : hip_q - 8'd1;
			push_step.down   = down_q;
		end
		push = step_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hip_low_q       <= RST_HIP_LOW;
			hip_high_q      <= RST_HIP_HIGH;
			thigh_lifted_q  <= RST_THIGH_LIFTED;
			thigh_lowered_q <= RST_THIGH_LOWERED;
			shin_lifted_q   <= RST_SHIN_LIFTED;
			shin_lowered_q  <= RST_SHIN_LOWERED;
			tick_interval_q <= RST_TICK_INTERVAL;
			sweep_mode_q    <= RST_SWEEP_MODE;
		end else if (cfg_wr_en) begin
			unique case (reg_sel)
				REG_HIP_LOW:       hip_low_q       <= cfg_data[7:0];
				REG_HIP_HIGH:      hip_high_q      <= cfg_data[7:0];
				REG_THIGH_LIFTED:  thigh_lifted_q  <= cfg_data[7:0];
				REG_THIGH_LOWERED: thigh_lowered_q <= cfg_data[7:0];
				REG_SHIN_LIFTED:   shin_lifted_q   <= cfg_data[7:0];
				REG_SHIN_LOWERED:  shin_lowered_q  <= cfg_data[7:0];
				REG_TICK_INTERVAL: tick_interval_q <= cfg_data;
				REG_SWEEP_MODE:    sweep_mode_q    <= cfg_data[1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hip_q       <= RST_SWEEP_MODE[0] ? RST_HIP_LOW : RST_HIP_HIGH;
			moving_up_q <= RST_SWEEP_MODE[0];
			down_q      <= 1'b1;
			elapsed_q   <= ELAPSED_MAX;
		end else begin
			if (cfg_wr_en) begin
				moving_up_q <= mode_nx[0];
				hip_q       <= mode_nx[0] ? low_nx : high_nx;
			end else if (step_go) begin
				if (!push_step.pair)
					hip_q <= push_step.angle0;
				else if (sweep_mode_q[1])
					moving_up_q <= !moving_up_q;
				down_q <= push_step.down;
			end
			if (accept && tick)
				elapsed_q <= step_go ? '0 : elapsed_inc;
		end
	end

endmodule

// File: hw/rtl/slss_queue.sv
// ============================================================================
// slss_queue
// Short step queue between the front and the result stage.
// ============================================================================
module slss_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  slss_pkg::step_t   push_step,
	input  logic              pop,
	output slss_pkg::step_t   head,
	output slss_pkg::q_stat_t stat
);
	import slss_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	step_t            mem [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: hw/rtl/slss_back.sv
// ============================================================================
// slss_back
// Result stage: expands queued steps into result items, converts angle to
// pulse and holds the output register.
// ============================================================================
module slss_back (
	input  logic              clk,
	input  logic              arst_n,
	input  slss_pkg::step_t   head,
	input  slss_pkg::q_stat_t stat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        joint,
	output logic [7:0]        angle,
	output logic [9:0]        pulse,
	output logic              leg_down,
	output logic              last
);
	import slss_pkg::*;

	logic       out_valid_q;
	logic       pend_q;
	logic [7:0] pend_angle_q;
	logic       pend_down_q;
	joint_t     joint_q;
	logic [7:0] angle_q;
	logic [9:0] pulse_q;
	logic       leg_down_q;
	logic       last_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = out_free && !pend_q && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (!stat.empty) begin
				out_valid_q <= 1'b1;
				pend_q      <= head.pair;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				joint_q    <= JOINT_TIBIA;
				angle_q    <= pend_angle_q;
				pulse_q    <= pulse_of(pend_angle_q);
				leg_down_q <= pend_down_q;
				last_q     <= 1'b1;
			end else if (!stat.empty) begin
				joint_q      <= head.pair ? JOINT_FEMUR : JOINT_HIP;
				angle_q      <= head.angle0;
				pulse_q      <= pulse_of(head.angle0);
				leg_down_q   <= head.down;
				last_q       <= !head.pair;
				pend_angle_q <= head.angle1;
				pend_down_q  <= head.down;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign joint     = joint_q;
	assign angle     = angle_q;
	assign pulse     = pulse_q;
	assign leg_down  = leg_down_q;
	assign last      = last_q;

endmodule

// File: hw/rtl/slss_checker.sv
// ============================================================================
// slss_checker
// Port-level checks on the result channel of the leg sweep sequencer.
// ============================================================================
module slss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] joint,
	input logic [7:0] angle,
	input logic [9:0] pulse,
	input logic       leg_down,
	input logic       last
);
	import slss_pkg::*;

	logic out_take;

	assign out_take = out_valid && !out_stall;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(joint) && $stable(angle)
			&& $stable(pulse) && $stable(leg_down) && $stable(last))
		else $error("stalled item changed");

	a_last_by_joint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (joint == JOINT_FEMUR && !last)
			|| ((joint == JOINT_HIP || joint == JOINT_TIBIA) && last))
		else $error("last flag does not match joint");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && joint == JOINT_FEMUR |=> out_valid && joint == JOINT_TIBIA
			&& leg_down == $past(leg_down))
		else $error("femur item not followed by matching tibia item");

	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pulse == pulse_of(angle))
		else $error("pulse does not match angle");

endmodule

bind servo_leg_sweep_sequencer slss_checker u_slss_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for servo_leg_sweep_sequencer. Drives tick items and
// register writes, predicts every servo command (hip steps, femur/tibia
// pairs at the sweep bounds) and checks each one field by field. The run
// covers directed bound cases, the longest tick interval and randomized
// sweep settings under sender gaps and receiver stalls.
// ============================================================================
module testbench;
	import slss_pkg::*;

	typedef struct {
		logic [1:0] joint;
		logic [7:0] angle;
		logic [9:0] pulse;
		logic       leg_down;
		logic       last;
	} servo_cmd_t;

	class leg_step_board;
		logic [7:0]           hip_low, hip_high;
		logic [7:0]           thigh_up, thigh_down, shin_up, shin_down;
		logic [15:0]          interval;
		logic [1:0]           mode;
		logic [7:0]           hip_pos;
		logic                 rising;
		logic [ELAPSED_W-1:0] elapsed;
		logic                 leg_is_down;
		servo_cmd_t           pending_cmds[$];
		int                   errors, ticks_seen, cmds_checked, bound_pairs;

		function new();
			hip_low     = RST_HIP_LOW;
			hip_high    = RST_HIP_HIGH;
			thigh_up    = RST_THIGH_LIFTED;
			thigh_down  = RST_THIGH_LOWERED;
			shin_up     = RST_SHIN_LIFTED;
			shin_down   = RST_SHIN_LOWERED;
			interval    = RST_TICK_INTERVAL;
			mode        = RST_SWEEP_MODE;
			elapsed     = ELAPSED_MAX;
			leg_is_down = 1'b1;
			reload_sweep();
		endfunction

		function void reload_sweep();
			rising  = mode[0];
			hip_pos = rising ? hip_low : hip_high;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] data);
			case (idx)
			REG_HIP_LOW:       hip_low    = data[7:0];
			REG_HIP_HIGH:      hip_high   = data[7:0];
			REG_THIGH_LIFTED:  thigh_up   = data[7:0];
			REG_THIGH_LOWERED: thigh_down = data[7:0];
			REG_SHIN_LIFTED:   shin_up    = data[7:0];
			REG_SHIN_LOWERED:  shin_down  = data[7:0];
			REG_TICK_INTERVAL: interval   = data;
			REG_SWEEP_MODE:    mode       = data[1:0];
			endcase
			reload_sweep();
		endfunction

		function logic [9:0] pulse_for(logic [7:0] a);
			int unsigned p;
			p = 120 + a * 460 / 180;
			if (p > 1023)
				p = 1023;
			return p[9:0];
		endfunction

		function void push_cmd(joint_t j, logic [7:0] a, logic fin);
			servo_cmd_t c;
			c.joint    = j;
			c.angle    = a;
			c.pulse    = pulse_for(a);
			c.leg_down = leg_is_down;
			c.last     = fin;
			pending_cmds.push_back(c);
		endfunction

		function void advance_on_tick(logic t);
			ticks_seen++;
			if (t !== 1'b1)
				return;
			if (elapsed != ELAPSED_MAX)
				elapsed++;
			if (elapsed <= {1'b0, interval})
				return;
			elapsed = '0;
			if (rising) begin
				if (hip_pos < hip_high) begin
					hip_pos++;
					push_cmd(JOINT_HIP, hip_pos, 1'b1);
					return;
				end
				if (mode[1])
					rising = 1'b0;
				leg_is_down = 1'b1;
				push_cmd(JOINT_FEMUR, thigh_up, 1'b0);
				push_cmd(JOINT_TIBIA, shin_up, 1'b1);
			end else begin
				if (hip_pos > hip_low) begin
					hip_pos--;
					push_cmd(JOINT_HIP, hip_pos, 1'b1);
					return;
				end
				if (mode[1])
					rising = 1'b1;
				leg_is_down = 1'b0;
				push_cmd(JOINT_FEMUR, thigh_down, 1'b0);
				push_cmd(JOINT_TIBIA, shin_down, 1'b1);
			end
			bound_pairs++;
		endfunction

		function void compare_field(string what, logic [9:0] want, logic [9:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
			end
		endfunction

		function void match_servo_cmd(logic [1:0] j, logic [7:0] a, logic [9:0] p,
				logic d, logic l);
			servo_cmd_t want;
			if (pending_cmds.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none actual joint %0d angle %0d",
					$time, j, a);
				return;
			end
			want = pending_cmds.pop_front();
			cmds_checked++;
			compare_field("joint", want.joint, j);
			compare_field("angle", want.angle, a);
			compare_field("pulse", want.pulse, p);
			compare_field("leg_down", want.leg_down, d);
			compare_field("last", want.last, l);
		endfunction

		function bit drained();
			return pending_cmds.size() == 0;
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  tick;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            joint;
	logic [7:0]            angle;
	logic [9:0]            pulse;
	logic                  leg_down;
	logic                  last;

	int            send_idle;
	int            recv_stall;
	leg_step_board board;

	servo_leg_sweep_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.tick      (tick),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.joint     (joint),
		.angle     (angle),
		.pulse     (pulse),
		.leg_down  (leg_down),
		.last      (last)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.match_servo_cmd(joint, angle, pulse, leg_down, last);
	end

	task automatic set_idling(int phase_kind);
		case (phase_kind)
		0: begin send_idle = 0;  recv_stall = 0;  end
		1: begin send_idle = 67; recv_stall = 0;  end
		2: begin send_idle = 0;  recv_stall = 67; end
		default: begin send_idle = 17; recv_stall = 17; end
		endcase
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_tick(logic t);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			tick     = $urandom_range(1);
			@(negedge clk);
		end
		in_valid = 1'b1;
		tick     = t;
		do @(posedge clk); while (in_stall);
		board.advance_on_tick(t);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (!board.drained())
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// upper data bits are don't-care for the narrow registers, so randomize them
	task automatic setup(logic [7:0] lo, logic [7:0] hi, logic [7:0] tu, logic [7:0] td,
			logic [7:0] su, logic [7:0] sd, logic [15:0] iv, logic [1:0] md);
		drain();
		repeat (4) @(negedge clk);
		write_reg(REG_HIP_LOW,       {8'($urandom), lo});
		write_reg(REG_HIP_HIGH,      {8'($urandom), hi});
		write_reg(REG_THIGH_LIFTED,  {8'($urandom), tu});
		write_reg(REG_THIGH_LOWERED, {8'($urandom), td});
		write_reg(REG_SHIN_LIFTED,   {8'($urandom), su});
		write_reg(REG_SHIN_LOWERED,  {8'($urandom), sd});
		write_reg(REG_TICK_INTERVAL, iv);
		write_reg(REG_SWEEP_MODE,    {14'($urandom), md});
	endtask

	task automatic random_setup();
		int unsigned lo, hi, span;
		logic [7:0]  a[4];
		logic [15:0] iv;
		lo   = $urandom_range(255);
		span = $urandom_range(6);
		case ($urandom_range(7))
		0: begin lo = 0; hi = span; end
		1: begin hi = 255; lo = 255 - span; end
		2: begin hi = $urandom_range(254); lo = $urandom_range(255, hi + 1); end
		default: hi = (lo + span > 255) ? 255 : lo + span;
		endcase
		foreach (a[k])
			a[k] = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
				: 8'($urandom_range(255));
		iv = ($urandom_range(9) == 0) ? 16'($urandom_range(20, 4)) : 16'($urandom_range(3));
		setup(lo, hi, a[0], a[1], a[2], a[3], iv, 2'($urandom_range(3)));
	endtask

	initial begin
		#4_000_000;
		$display("servo_leg_sweep_sequencer verification failed");
		$finish;
	end

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		tick       = 1'b0;
		send_idle  = 0;
		recv_stall = 0;
		board      = new();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// reset values: first tick steps at once, then the interval holds
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);

		// narrow sweep at the bottom, reversing, extreme joint angles
		setup(8'd0, 8'd1, 8'd255, 8'd0, 8'd0, 8'd255, 16'd0, 2'd3);
		repeat (6) send_tick(1'b1);
		send_tick(1'b0);

		// top of range moving up, no reversal: stays at the upper bound
		setup(8'd254, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 16'd1, 2'd1);
		repeat (6) send_tick(1'b1);

		// inverted bounds, starting downward with reversal
		setup(8'd200, 8'd100, 8'd17, 8'd99, 8'd180, 8'd3, 16'd0, 2'd2);
		repeat (3) send_tick(1'b1);

		// downward, no reversal
		setup(8'd10, 8'd12, 8'd40, 8'd60, 8'd70, 8'd90, 16'd0, 2'd0);
		repeat (5) send_tick(1'b1);

		// longest interval: ticks only accumulate, no step
		setup(RST_HIP_LOW, RST_HIP_HIGH, RST_THIGH_LIFTED, RST_THIGH_LOWERED,
			RST_SHIN_LIFTED, RST_SHIN_LOWERED, 16'hFFFF, RST_SWEEP_MODE);
		repeat (20) send_tick(1'b1);

		for (int phase = 0; phase < 10; phase++) begin
			random_setup();
			set_idling(phase % 4);
			for (int i = 0; i < 42; i++) begin
				if (i == 22 && phase % 3 == 1)
					drain();
				send_tick($urandom_range(99) < 85);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Run: %0d tick items, %0d servo commands checked, %0d bound pairs,",
			board.ticks_seen, board.cmds_checked, board.bound_pairs);
		$display("  directed bound/inverted/extreme cases plus 10 random sweep settings.");
		if (board.errors == 0)
			$display("servo_leg_sweep_sequencer verification clean");
		else
			$display("servo_leg_sweep_sequencer verification failed");
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/slss_pkg.sv
hw/rtl/slss_front.sv
hw/rtl/slss_queue.sv
hw/rtl/slss_back.sv
hw/rtl/servo_leg_sweep_sequencer.sv
hw/rtl/slss_checker.sv
bench/testbench.sv
